>>> rtl/abs_pkg.sv
// abs_pkg: shared types and codes for the array bag and stack store
// depends on nothing; imported by array_bag_stack_store_core and the testbench
package abs_pkg;

    // payload widths fixed by the interface
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 8;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;

    // default store depth
    localparam int DEF_CAPACITY = 128;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [VALUE_W-1:0]  word_t;

    // request codes
    localparam mode_t MODE_INSERT   = 3'd0;
    localparam mode_t MODE_CONTAINS = 3'd1;
    localparam mode_t MODE_REMOVE   = 3'd2;
    localparam mode_t MODE_TOP      = 3'd3;
    localparam mode_t MODE_POP      = 3'd4;

    // result status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_EMPTY     = 2'd3;

endpackage

>>> rtl/array_bag_stack_store_core.sv
// array_bag_stack_store_core: fixed-capacity bag / stack held in one
// synchronous memory with a sequencer for scan, shift and top read
// depends on abs_pkg
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_ready  | mode, value
//  out     | output    | out_valid/out_ready| status, found, top_value, item_count,
//          |           |                    | is_empty
//
// insert, pop and unused codes finish in the accept cycle; top reads the memory, then loads the result in S_TOPW
// contains does one memory read per cycle, newest entry first
// remove then shifts the later entries down, one read and one write per cycle
// one request is in flight at a time; a new beat is taken while the last result
// is handed over, and a stalled result holds the block off
// reset clears the state, the count and the result valid only; the entry memory needs no clearing pass
module array_bag_stack_store_core #(
    parameter int CAPACITY = abs_pkg::DEF_CAPACITY
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  abs_pkg::mode_t                        mode,
    input  logic signed [abs_pkg::VALUE_W-1:0]    value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output abs_pkg::status_t                      status,
    output logic                                  found,
    output logic signed [abs_pkg::VALUE_W-1:0]    top_value,
    output logic [abs_pkg::COUNT_OUT_W-1:0]       item_count,
    output logic                                  is_empty
);
    import abs_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_TOPW  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next;
    mode_t         mode_reg;
    word_t         value_reg;

    logic          out_valid_reg, out_valid_next;
    status_t       status_reg;
    logic          found_reg;
    word_t         top_value_reg;
    logic [COUNT_OUT_W-1:0] item_count_reg;
    logic          is_empty_reg;

    // entry memory
    word_t         mem [CAPACITY];
    word_t         rdata_reg;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    word_t         wr_data;

    // result being loaded
    logic          out_load;
    status_t       res_status;
    logic          res_found;
    word_t         res_top;

    logic          in_fire;
    logic [CW-1:0] count_m1;
    logic          store_empty;
    logic          hit;
    logic [CW:0]   idx_ext;
    logic [CW:0]   count_ext;
    logic [CW+COUNT_OUT_W-1:0] count_wide;

    assign in_ready    = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire     = in_valid && in_ready;
    assign count_m1    = count_reg - 1'b1;
    assign store_empty = (count_reg == '0);
    assign hit         = (rdata_reg == value_reg);
    assign idx_ext     = (CW+1)'(idx_reg);
    assign count_ext   = {1'b0, count_reg};
    assign count_wide  = {{COUNT_OUT_W{1'b0}}, count_next};

    // sequencer and read-modify-write control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        rd_addr    = count_m1[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = word_t'(value);
        out_load   = 1'b0;
        res_status = ST_OK;
        res_found  = 1'b0;
        res_top    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (mode) inside
                        MODE_INSERT:
                        begin
                            out_load = 1'b1;
                            if (count_reg != CAP_C)
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                res_status = ST_FULL;
                            end
                        end
                        MODE_CONTAINS, MODE_REMOVE:
                        begin
                            if (store_empty)
                            begin
                                out_load   = 1'b1;
                                res_status = (mode == MODE_REMOVE) ? ST_NOT_FOUND : ST_OK;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                idx_next   = count_m1[AW-1:0];
                                state_next = S_SCAN;
                            end
                        end
                        MODE_TOP:
                        begin
                            if (store_empty)
                            begin
                                out_load   = 1'b1;
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_TOPW;
                            end
                        end
                        MODE_POP:
                        begin
                            out_load = 1'b1;
                            if (store_empty)
                                res_status = ST_EMPTY;
                            else
                                count_next = count_m1;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // rdata_reg holds entry idx_reg; walk from newest to oldest
                if (hit)
                begin
                    if (mode_reg == MODE_CONTAINS)
                    begin
                        out_load   = 1'b1;
                        res_found  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (idx_ext + 1'b1 < count_ext)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_reg + 1'b1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next = count_m1;
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (idx_reg == '0)
                begin
                    out_load   = 1'b1;
                    res_status = (mode_reg == MODE_CONTAINS) ? ST_OK : ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg - 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_SHIFT:
            begin
                // rdata_reg holds entry idx_reg+1; move it down one place
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rdata_reg;
                if (idx_ext + 2'd2 < count_ext)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_ext + 2'd2);
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_m1;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TOPW:
            begin
                out_load   = 1'b1;
                res_top    = rdata_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and scan registers
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (in_fire)
        begin
            mode_reg  <= mode;
            value_reg <= word_t'(value);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg     <= res_status;
            found_reg      <= res_found;
            top_value_reg  <= res_top;
            item_count_reg <= count_wide[COUNT_OUT_W-1:0];
            is_empty_reg   <= (count_next == '0);
        end
    end

    // entry memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // entry memory read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign found      = found_reg;
    assign top_value  = top_value_reg;
    assign item_count = item_count_reg;
    assign is_empty   = is_empty_reg;

    // count stays within the store
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    // count moves by at most one per request
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped");

    // read and write never hit the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write to same entry");

    // a hit only ever comes with ok status on a non-empty store
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (status == ST_OK && !is_empty))
        else $error("found with bad status");

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for array_bag_stack_store_core, a directed table
// then random fill / drain / mixed traffic scored against a behavioral store model
// depends on abs_pkg and array_bag_stack_store_core
module testbench;

    import abs_pkg::*;

    localparam int STORE_DEPTH  = DEF_CAPACITY;
    localparam int TOTAL_BEATS  = 1000;
    localparam int CALM_TAIL    = 100;
    localparam int HOLD_AT      = 250;
    localparam int HOLD_CYCLES  = 600;
    localparam int PAUSE_AT     = 600;
    localparam int END_WAIT     = 2 * STORE_DEPTH + 32;
    localparam int CYCLE_LIMIT  = 1200000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        status_t          status;
        logic             found;
        word_t            top_value;
        logic [7:0]       item_count;
        logic             is_empty;
    } outcome_t;

    typedef struct {
        mode_t    op;
        word_t    operand;
        bit       pinned;
        outcome_t want;
    } table_row_t;

    typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

    // bench signals
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    mode_t                 mode      = MODE_INSERT;
    logic signed [31:0]    value     = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    status_t               status;
    logic                  found;
    logic signed [31:0]    top_value;
    logic [7:0]            item_count;
    logic                  is_empty;

    // pinned expectation travels with the beat it belongs to
    logic                  row_pinned = 1'b0;
    outcome_t              row_want   = '0;

    // model of the store contents
    word_t                 held [STORE_DEPTH];
    int                    held_count = 0;
    outcome_t              pending_results [$];

    // run bookkeeping
    int                    beats_sent     = 0;
    int                    fault_count    = 0;
    int                    cycle_count    = 0;
    int                    results_seen   = 0;
    int                    full_seen      = 0;
    int                    miss_seen      = 0;
    int                    empty_seen     = 0;
    int                    deepest_fill   = 0;
    bit                    calm           = 1'b0;
    bit                    long_hold_done = 1'b0;

    array_bag_stack_store_core #(
        .CAPACITY(STORE_DEPTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .found      (found),
        .top_value  (top_value),
        .item_count (item_count),
        .is_empty   (is_empty)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // reset, once
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // newest index holding v, or -1
    function automatic int last_match(word_t v);
        int spot;
        spot = -1;
        for (int i = 0; i < held_count; i++)
            if (held[i] == v)
                spot = i;
        return spot;
    endfunction

    // store behavior: update the model and return the result of one request
    function automatic outcome_t apply_request(mode_t op, word_t v);
        outcome_t r;
        int       spot;
        r = '0;
        r.status = ST_OK;
        case (op)
            MODE_INSERT:
                if (held_count < STORE_DEPTH)
                begin
                    held[held_count] = v;
                    held_count++;
                end
                else
                    r.status = ST_FULL;
            MODE_CONTAINS:
                r.found = (last_match(v) >= 0);
            MODE_REMOVE:
            begin
                spot = last_match(v);
                if (spot >= 0)
                begin
                    for (int i = spot; i + 1 < held_count; i++)
                        held[i] = held[i + 1];
                    held_count--;
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            MODE_TOP:
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                    r.top_value = held[held_count - 1];
            MODE_POP:
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                    held_count--;
            default: ;
        endcase
        r.item_count = 8'(held_count);
        r.is_empty   = (held_count == 0);
        return r;
    endfunction

    function automatic outcome_t make_outcome(status_t st, logic f, word_t tv,
                                              int cnt, logic emp);
        outcome_t r;
        r.status     = st;
        r.found      = f;
        r.top_value  = tv;
        r.item_count = 8'(cnt);
        r.is_empty   = emp;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fault_count++;
            if (fault_count <= SHOW_LIMIT)
                $display("result %0d: %s expected %h, got %h",
                         results_seen, name, want, got);
        end
    endtask

    // predict on accepted input beats, score accepted output beats
    always @(posedge clk)
    begin : scoreboard
        outcome_t want;
        if (rst_n && in_valid && in_ready)
        begin
            want = apply_request(mode, value);
            if (row_pinned)
                want = row_want;
            pending_results.push_back(want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT)
                    $display("result %0d arrived with nothing expected", results_seen);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("found", 32'(want.found), 32'(found));
                check_field("top_value", want.top_value, top_value);
                check_field("item_count", 32'(want.item_count), 32'(item_count));
                check_field("is_empty", 32'(want.is_empty), 32'(is_empty));
                if (want.status == ST_FULL)      full_seen++;
                if (want.status == ST_NOT_FOUND) miss_seen++;
                if (want.status == ST_EMPTY)     empty_seen++;
                if (int'(want.item_count) > deepest_fill)
                    deepest_fill = int'(want.item_count);
            end
        end
    end

    // result side: short random stalls, one long hold-off, none near the end
    initial
    begin : result_sink
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && beats_sent >= HOLD_AT)
            begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // offer one beat, with an occasional idle burst ahead of it
    task automatic send_beat(mode_t op, word_t v, bit pin, outcome_t want);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        value      <= v;
        row_pinned <= pin;
        row_want   <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        calm = (beats_sent >= TOTAL_BEATS - CALM_TAIL);
    endtask

    function automatic mode_t pick_mode(seg_kind_t kind);
        int r;
        int c_ins, c_has, c_rem, c_top, c_pop;
        r = $urandom_range(0, 99);
        case (kind)
            SEG_FILL:  begin c_ins = 90; c_has = 94; c_rem = 95; c_top = 98; c_pop = 99; end
            SEG_DRAIN: begin c_ins = 15; c_has = 25; c_rem = 60; c_top = 70; c_pop = 97; end
            default:   begin c_ins = 35; c_has = 55; c_rem = 75; c_top = 85; c_pop = 97; end
        endcase
        if (r < c_ins)      return MODE_INSERT;
        else if (r < c_has) return MODE_CONTAINS;
        else if (r < c_rem) return MODE_REMOVE;
        else if (r < c_top) return MODE_TOP;
        else if (r < c_pop) return MODE_POP;
        else                return mode_t'(MODE_POP + $urandom_range(1, 3));
    endfunction

    // operands: often a held value so searches hit, often a small or extreme one
    function automatic word_t pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && held_count > 0)
            return held[$urandom_range(0, held_count - 1)];
        else if (r < 7)
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                default: return word_t'($urandom_range(0, 6) - 3);
            endcase
        else
            return $urandom;
    endfunction

    // stimulus
    initial
    begin : stimulus
        table_row_t rows [$];
        seg_kind_t  kind;
        int         seg_left;
        bit         paused;
        mode_t      op;

        // directed table: empty-store cases, extremes, duplicates, every code
        rows.push_back('{MODE_TOP,      32'd0,          1, make_outcome(ST_EMPTY, 0, 0, 0, 1)});
        rows.push_back('{MODE_POP,      32'd9,          1, make_outcome(ST_EMPTY, 0, 0, 0, 1)});
        rows.push_back('{MODE_REMOVE,   32'd5,          1, make_outcome(ST_NOT_FOUND, 0, 0, 0, 1)});
        rows.push_back('{MODE_CONTAINS, 32'd5,          1, make_outcome(ST_OK, 0, 0, 0, 1)});
        rows.push_back('{mode_t'(MODE_POP + 1), 32'hffff_ffff, 1,
                         make_outcome(ST_OK, 0, 0, 0, 1)});
        rows.push_back('{MODE_INSERT,   32'h8000_0000,  1, make_outcome(ST_OK, 0, 0, 1, 0)});
        rows.push_back('{MODE_INSERT,   32'h7fff_ffff,  1, make_outcome(ST_OK, 0, 0, 2, 0)});
        rows.push_back('{MODE_TOP,      32'd0,          1,
                         make_outcome(ST_OK, 0, 32'h7fff_ffff, 2, 0)});
        rows.push_back('{MODE_INSERT,   32'd0,          1, make_outcome(ST_OK, 0, 0, 3, 0)});
        rows.push_back('{MODE_INSERT,   32'hffff_ffff,  1, make_outcome(ST_OK, 0, 0, 4, 0)});
        rows.push_back('{MODE_INSERT,   32'h7fff_ffff,  0, '0});
        rows.push_back('{MODE_CONTAINS, 32'h8000_0000,  1, make_outcome(ST_OK, 1, 0, 5, 0)});
        rows.push_back('{MODE_CONTAINS, 32'h1234_5678,  1, make_outcome(ST_OK, 0, 0, 5, 0)});
        rows.push_back('{MODE_REMOVE,   32'h7fff_ffff,  0, '0});
        rows.push_back('{MODE_TOP,      32'h5555_5555,  0, '0});
        rows.push_back('{MODE_REMOVE,   32'h8000_0000,  0, '0});
        rows.push_back('{mode_t'(MODE_POP + 2), 32'h1234_5678, 0, '0});
        rows.push_back('{mode_t'(MODE_POP + 3), 32'hdead_beef, 0, '0});
        rows.push_back('{MODE_POP,      32'd0,          0, '0});
        rows.push_back('{MODE_TOP,      32'd0,          0, '0});
        rows.push_back('{MODE_REMOVE,   32'd0,          0, '0});
        rows.push_back('{MODE_REMOVE,   32'd0,          0, '0});
        rows.push_back('{MODE_POP,      32'd0,          0, '0});
        rows.push_back('{MODE_POP,      32'd0,          0, '0});
        rows.push_back('{MODE_TOP,      32'd0,          0, '0});

        @(posedge rst_n);
        @(posedge clk);
        foreach (rows[i])
            send_beat(rows[i].op, rows[i].operand, rows[i].pinned, rows[i].want);

        // random segments, the first one fills the store past capacity
        kind     = SEG_FILL;
        seg_left = $urandom_range(160, 220);
        paused   = 1'b0;
        while (beats_sent < TOTAL_BEATS)
        begin
            if (seg_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       begin kind = SEG_FILL;  seg_left = $urandom_range(160, 220); end
                    1:       begin kind = SEG_DRAIN; seg_left = $urandom_range(100, 180); end
                    default: begin kind = SEG_MIXED; seg_left = $urandom_range(40, 120);  end
                endcase
            end
            // sender goes quiet until the block has handed back everything
            if (!paused && beats_sent >= PAUSE_AT)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            op = pick_mode(kind);
            send_beat(op, pick_operand(), 1'b0, '0);
            seg_left--;
        end

        // drain and report
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);
        $display("%0d requests scored: %0d full, %0d not found, %0d empty results",
                 results_seen, full_seen, miss_seen, empty_seen);
        $display("deepest fill %0d of %0d entries, %0d field mismatches",
                 deepest_fill, STORE_DEPTH, fault_count);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
